// ===== hw/rtl/sfb_pkg.sv =====
// Shared types, widths and helpers for the seam feather blend block.
`default_nettype none

package sfb_pkg;

    localparam int MAX_WIDTH_VAL = 4096;
    localparam int COL_W = $clog2(MAX_WIDTH_VAL);
    localparam int DEN_W = COL_W + 1;
    localparam int PIX_W = 8;
    localparam int NUM_W = DEN_W + PIX_W;
    localparam int CHANNELS = 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = PIX_W / STEPS_PER_STAGE;

    localparam logic [DEN_W-1:0] MAX_WIDTH = DEN_W'(MAX_WIDTH_VAL);
    localparam logic [DEN_W-1:0] WIDTH_RESET = DEN_W'(MAX_WIDTH_VAL);

    localparam int ADDR_W = 3;
    localparam logic REG_OVERLAP_START = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] overlap_start;
        logic [DEN_W-1:0] image_width;
    } cfg_t;

    typedef struct packed {
        logic                          valid;
        logic                          wen;
        logic                          black;
        pixel_t                        first;
        logic [CHANNELS-1:0][NUM_W-1:0] rem;
        pixel_t                        quo;
    } pipe_t;

    function automatic logic [DEN_W-1:0] clamp_width(input logic [DEN_W-1:0] w);
        clamp_width = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/seam_linear_feather_blend.sv =====
// Top level of the seam feather blend: register file, front stages, divider, output.
//
// Usage:
//   Configuration goes through the APB port: overlap_start at byte address 0,
//   image_width at byte address 4. pready is always high. Write the registers
//   only while no transaction is in flight.
//   A pixel pair is taken at each rising edge with start high and busy low.
//   busy is always low, so a new transaction may enter on every clock.
//   Each transaction gives one result: done is high for exactly one cycle
//   with write_enable and out_c0..out_c2 valid in that cycle.
//   A result passes through the input register, product stage, sum stage,
//   four divider stages and output register on its way to the ports.
//   Throughput: one pixel per clock, set by the fully pipelined divider that
//   retires two quotient bits per stage.
//   Results leave in the order taken; the receiver cannot stall them.
//   Reset clears all valid bits and returns the registers to overlap_start 0
//   and image_width 4096; transactions in flight are dropped.
`default_nettype none

module seam_linear_feather_blend (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [sfb_pkg::COL_W-1:0]  column,
    input  wire logic [sfb_pkg::PIX_W-1:0]  first_c0,
    input  wire logic [sfb_pkg::PIX_W-1:0]  first_c1,
    input  wire logic [sfb_pkg::PIX_W-1:0]  first_c2,
    input  wire logic [sfb_pkg::PIX_W-1:0]  second_c0,
    input  wire logic [sfb_pkg::PIX_W-1:0]  second_c1,
    input  wire logic [sfb_pkg::PIX_W-1:0]  second_c2,
    output logic                            done,
    output logic                            write_enable,
    output logic      [sfb_pkg::PIX_W-1:0]  out_c0,
    output logic      [sfb_pkg::PIX_W-1:0]  out_c1,
    output logic      [sfb_pkg::PIX_W-1:0]  out_c2
);

    sfb_pkg::cfg_t             cfg;
    sfb_pkg::pixel_t           first_pix;
    sfb_pkg::pixel_t           second_pix;
    sfb_pkg::pipe_t            chain [sfb_pkg::DIV_STAGES+1];
    logic [sfb_pkg::DEN_W-1:0] den;

    logic            done_reg;
    logic            write_enable_reg;
    sfb_pkg::pixel_t out_reg;
    sfb_pkg::pixel_t out_next;

    assign busy       = 1'b0;
    assign first_pix  = {first_c2, first_c1, first_c0};
    assign second_pix = {second_c2, second_c1, second_c0};
    assign den        = sfb_pkg::clamp_width(cfg.image_width) - {1'b0, cfg.overlap_start};

    sfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .column   (column),
        .first    (first_pix),
        .second   (second_pix),
        .cfg      (cfg),
        .pipe_out (chain[0])
    );

    for (genvar g = 0; g < sfb_pkg::DIV_STAGES; g++)
    begin : g_div
        sfb_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .den      (den),
            .pipe_in  (chain[g]),
            .pipe_out (chain[g+1])
        );
    end

    always_comb
    begin
        priority if (!chain[sfb_pkg::DIV_STAGES].wen)
        begin
            out_next = '0;
        end
        else if (chain[sfb_pkg::DIV_STAGES].black)
        begin
            out_next = chain[sfb_pkg::DIV_STAGES].first;
        end
        else
        begin
            out_next = chain[sfb_pkg::DIV_STAGES].quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[sfb_pkg::DIV_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        write_enable_reg <= chain[sfb_pkg::DIV_STAGES].wen;
        out_reg          <= out_next;
    end

    assign done         = done_reg;
    assign write_enable = write_enable_reg;
    assign out_c0       = out_reg[0];
    assign out_c1       = out_reg[1];
    assign out_c2       = out_reg[2];

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_cfg.sv =====
// APB register file holding the overlap start and image width.
`default_nettype none

module sfb_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output sfb_pkg::cfg_t                   cfg
);

    logic [sfb_pkg::COL_W-1:0] overlap_start_reg;
    logic [sfb_pkg::DEN_W-1:0] image_width_reg;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_start_reg <= '0;
            image_width_reg   <= sfb_pkg::WIDTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sfb_pkg::REG_OVERLAP_START:
                    overlap_start_reg <= pwdata[sfb_pkg::COL_W-1:0];
                sfb_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= pwdata[sfb_pkg::DEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sfb_pkg::REG_OVERLAP_START:
                prdata[sfb_pkg::COL_W-1:0] = overlap_start_reg;
            sfb_pkg::REG_IMAGE_WIDTH:
                prdata[sfb_pkg::DEN_W-1:0] = image_width_reg;
            default: ;
        endcase
    end

    assign cfg.overlap_start = overlap_start_reg;
    assign cfg.image_width   = image_width_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_front.sv =====
// Front stages: input capture, range check and weights, products, numerator sum.
`default_nettype none

module sfb_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sfb_pkg::COL_W-1:0] column,
    input  wire sfb_pkg::pixel_t           first,
    input  wire sfb_pkg::pixel_t           second,
    input  wire sfb_pkg::cfg_t             cfg,
    output sfb_pkg::pipe_t                 pipe_out
);

    // stage A: input register
    logic                      a_valid_reg;
    logic [sfb_pkg::COL_W-1:0] a_col_reg;
    sfb_pkg::pixel_t           a_first_reg;
    sfb_pkg::pixel_t           a_second_reg;

    // stage B: products
    logic                                              b_valid_reg;
    logic                                              b_wen_reg;
    logic                                              b_black_reg;
    sfb_pkg::pixel_t                                   b_first_reg;
    logic [sfb_pkg::CHANNELS-1:0][sfb_pkg::NUM_W-1:0]  b_pa_reg;
    logic [sfb_pkg::CHANNELS-1:0][sfb_pkg::NUM_W-1:0]  b_pb_reg;
    logic [sfb_pkg::CHANNELS-1:0][sfb_pkg::NUM_W-1:0]  b_pa_next;
    logic [sfb_pkg::CHANNELS-1:0][sfb_pkg::NUM_W-1:0]  b_pb_next;

    // stage C: numerator
    sfb_pkg::pipe_t c_reg;
    sfb_pkg::pipe_t c_next;

    logic [sfb_pkg::DEN_W-1:0] w_eff;
    logic [sfb_pkg::DEN_W-1:0] w_minus_col;
    logic [sfb_pkg::COL_W-1:0] col_minus_s;
    logic                      in_range;
    logic                      black;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_reg.valid <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_reg       <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_col_reg    <= column;
            a_first_reg  <= first;
            a_second_reg <= second;
        end
    end

    assign w_eff       = sfb_pkg::clamp_width(cfg.image_width);
    assign in_range    = (a_col_reg >= cfg.overlap_start) &&
                         ({1'b0, a_col_reg} < w_eff);
    assign black       = (a_second_reg == '0);
    assign w_minus_col = w_eff - {1'b0, a_col_reg};
    assign col_minus_s = a_col_reg - cfg.overlap_start;

    always_comb
    begin
        for (int ch = 0; ch < sfb_pkg::CHANNELS; ch++)
        begin
            b_pa_next[ch] = {{sfb_pkg::DEN_W{1'b0}}, a_first_reg[ch]} *
                            {{sfb_pkg::PIX_W{1'b0}}, w_minus_col};
            b_pb_next[ch] = {{sfb_pkg::DEN_W{1'b0}}, a_second_reg[ch]} *
                            {{(sfb_pkg::PIX_W + 1){1'b0}}, col_minus_s};
        end
    end

    always_ff @(posedge clk)
    begin
        b_wen_reg   <= in_range;
        b_black_reg <= black;
        b_first_reg <= a_first_reg;
        b_pa_reg    <= b_pa_next;
        b_pb_reg    <= b_pb_next;
    end

    always_comb
    begin
        c_next.valid = b_valid_reg;
        c_next.wen   = b_wen_reg;
        c_next.black = b_black_reg;
        c_next.first = b_first_reg;
        c_next.quo   = '0;
        for (int ch = 0; ch < sfb_pkg::CHANNELS; ch++)
        begin
            c_next.rem[ch] = b_pa_reg[ch] + b_pb_reg[ch];
        end
    end

    assign pipe_out = c_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_div_stage.sv =====
// One registered stage of the restoring divider: two quotient bits per channel.
`default_nettype none

module sfb_div_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [sfb_pkg::DEN_W-1:0] den,
    input  wire sfb_pkg::pipe_t            pipe_in,
    output sfb_pkg::pipe_t                 pipe_out
);

    sfb_pkg::pipe_t           stage_reg;
    sfb_pkg::pipe_t           stage_next;
    logic [sfb_pkg::NUM_W-1:0] den_al;

    // divisor aligned to the top quotient bit
    assign den_al = {1'b0, den, {(sfb_pkg::PIX_W - 1){1'b0}}};

    always_comb
    begin
        logic [sfb_pkg::NUM_W-1:0] r;
        logic [sfb_pkg::PIX_W-1:0] q;
        stage_next = pipe_in;
        for (int ch = 0; ch < sfb_pkg::CHANNELS; ch++)
        begin
            r = pipe_in.rem[ch];
            q = pipe_in.quo[ch];
            for (int st = 0; st < sfb_pkg::STEPS_PER_STAGE; st++)
            begin
                if (r >= den_al)
                begin
                    r = r - den_al;
                    q = {q[sfb_pkg::PIX_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[sfb_pkg::PIX_W-2:0], 1'b0};
                end
                r = {r[sfb_pkg::NUM_W-2:0], 1'b0};
            end
            stage_next.rem[ch] = r;
            stage_next.quo[ch] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign pipe_out = stage_reg;

endmodule

`default_nettype wire

// ===== dv/seam_linear_feather_blend_tb.sv =====
// Testbench for seam_linear_feather_blend with a blend predictor and random traffic.
`timescale 1ns / 100ps

module seam_linear_feather_blend_tb;

    localparam int CLK_HALF       = 4;
    localparam int MAX_COLS       = sfb_pkg::MAX_WIDTH_VAL;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 630;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [sfb_pkg::COL_W-1:0] column;
        sfb_pkg::pixel_t           first;
        sfb_pkg::pixel_t           second;
    } pixel_pair_t;

    typedef struct packed {
        logic            wen;
        sfb_pkg::pixel_t pix;
    } blend_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sfb_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic start;
    logic busy;
    pixel_pair_t pair_drv;
    logic done;
    logic write_enable;
    logic [sfb_pkg::PIX_W-1:0] out_c0;
    logic [sfb_pkg::PIX_W-1:0] out_c1;
    logic [sfb_pkg::PIX_W-1:0] out_c2;

    logic [sfb_pkg::COL_W-1:0] cfg_start;
    logic [sfb_pkg::DEN_W-1:0] cfg_width;

    blend_result_t blend_queue[$];
    int unsigned   mismatches;
    int unsigned   cycles;
    int unsigned   random_sent;

    seam_linear_feather_blend dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .column       (pair_drv.column),
        .first_c0     (pair_drv.first[0]),
        .first_c1     (pair_drv.first[1]),
        .first_c2     (pair_drv.first[2]),
        .second_c0    (pair_drv.second[0]),
        .second_c1    (pair_drv.second[1]),
        .second_c2    (pair_drv.second[2]),
        .done         (done),
        .write_enable (write_enable),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    function automatic blend_result_t predict_blend(pixel_pair_t p,
                                                    logic [sfb_pkg::COL_W-1:0] s,
                                                    logic [sfb_pkg::DEN_W-1:0] w);
        blend_result_t r;
        int unsigned   wc;
        int unsigned   col;
        int unsigned   num;
        int unsigned   q;
        r   = '0;
        wc  = (int'(w) > MAX_COLS) ? MAX_COLS : int'(w);
        col = p.column;
        if (col < s || col >= wc)
            return r;
        r.wen = 1'b1;
        if (p.second == '0)
        begin
            r.pix = p.first;
        end
        else
        begin
            for (int ch = 0; ch < sfb_pkg::CHANNELS; ch++)
            begin
                num = p.first[ch] * (wc - col) + p.second[ch] * (col - s);
                q   = num / (wc - s);
                r.pix[ch] = (q > 255) ? 8'd255 : q[7:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // transaction monitor: result check first, then prediction of the accepted pair
    always @(posedge clk)
    begin
        blend_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (blend_queue.size() == 0)
                begin
                    report_mismatch("done with no transaction pending", 1, 0);
                end
                else
                begin
                    want = blend_queue.pop_front();
                    if (write_enable !== want.wen)
                        report_mismatch("write_enable", write_enable, want.wen);
                    if (out_c0 !== want.pix[0])
                        report_mismatch("out_c0", out_c0, want.pix[0]);
                    if (out_c1 !== want.pix[1])
                        report_mismatch("out_c1", out_c1, want.pix[1]);
                    if (out_c2 !== want.pix[2])
                        report_mismatch("out_c2", out_c2, want.pix[2]);
                end
            end
            if (start && !busy)
                blend_queue = {blend_queue, predict_blend(pair_drv, cfg_start, cfg_width)};
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("seam_linear_feather_blend_tb: done, errors");
            $finish;
        end
    end

    function automatic pixel_pair_t pack_pair(int unsigned col, int unsigned f0,
                                              int unsigned f1, int unsigned f2,
                                              int unsigned t0, int unsigned t1,
                                              int unsigned t2);
        pixel_pair_t p;
        p.column    = col[sfb_pkg::COL_W-1:0];
        p.first[0]  = f0[7:0];
        p.first[1]  = f1[7:0];
        p.first[2]  = f2[7:0];
        p.second[0] = t0[7:0];
        p.second[1] = t1[7:0];
        p.second[2] = t2[7:0];
        return p;
    endfunction

    task automatic send_pair(pixel_pair_t p, int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        pair_drv <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (blend_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic regsel, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (regsel == sfb_pkg::REG_OVERLAP_START)
            cfg_start = value[sfb_pkg::COL_W-1:0];
        else
            cfg_width = value[sfb_pkg::DEN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int unsigned s, int unsigned w);
        drain_pipeline();
        apb_write(sfb_pkg::REG_IMAGE_WIDTH, w);
        apb_write(sfb_pkg::REG_OVERLAP_START, s);
    endtask

    task automatic test_reset_defaults();
        send_pair(pack_pair(0, 0, 0, 0, 255, 255, 255), 0);
        send_pair(pack_pair(4095, 255, 255, 255, 1, 0, 0), 0);
        send_pair(pack_pair(2048, 255, 128, 1, 0, 0, 0), 2);
        send_pair(pack_pair(1024, 200, 17, 99, 3, 250, 64), 0);
    endtask

    task automatic test_overlap_edges();
        set_config(100, 200);
        send_pair(pack_pair(99, 255, 255, 255, 255, 255, 255), 0);
        send_pair(pack_pair(100, 255, 0, 128, 0, 255, 7), 0);
        send_pair(pack_pair(199, 0, 255, 128, 255, 0, 9), 1);
        send_pair(pack_pair(200, 255, 255, 255, 255, 255, 255), 0);
        send_pair(pack_pair(150, 255, 255, 255, 255, 255, 255), 0);
        send_pair(pack_pair(151, 10, 20, 30, 240, 230, 220), 3);
    endtask

    task automatic test_black_warped();
        set_config(0, 16);
        send_pair(pack_pair(8, 12, 34, 56, 0, 0, 0), 0);
        send_pair(pack_pair(15, 255, 255, 255, 0, 0, 0), 0);
        send_pair(pack_pair(0, 90, 91, 92, 0, 0, 1), 0);
        send_pair(pack_pair(16, 90, 91, 92, 0, 0, 0), 0);
    endtask

    task automatic test_empty_overlap();
        set_config(300, 300);
        send_pair(pack_pair(300, 255, 255, 255, 255, 255, 255), 0);
        set_config(4095, 0);
        send_pair(pack_pair(0, 1, 2, 3, 4, 5, 6), 0);
        set_config(12, 5);
        send_pair(pack_pair(7, 1, 2, 3, 4, 5, 6), 0);
    endtask

    task automatic test_wide_width();
        set_config(4095, 8191);
        send_pair(pack_pair(4095, 77, 0, 255, 255, 3, 0), 0);
        set_config(0, 4097);
        send_pair(pack_pair(4095, 0, 255, 40, 255, 0, 41), 0);
        send_pair(pack_pair(0, 255, 255, 255, 255, 255, 255), 0);
    endtask

    function automatic int unsigned rand_channel();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic test_random();
        int unsigned s;
        int unsigned w;
        int unsigned wc;
        int unsigned col;
        int unsigned n;
        int unsigned gap;
        bit          no_idle;
        pixel_pair_t p;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: begin s = 0; w = MAX_COLS; end
                1: begin s = 4095; w = MAX_COLS; end
                2: begin s = 0; w = 1; end
                3: begin s = $urandom_range(0, 4095); w = $urandom_range(4097, 8191); end
                4: begin s = $urandom_range(0, 4080); w = s + $urandom_range(1, 16); end
                5: begin s = $urandom_range(0, 4095); w = $urandom_range(0, s); end
                default: begin s = $urandom_range(0, 4000); w = $urandom_range(s + 1, 4096); end
            endcase
            set_config(s, w);
            wc      = (w > MAX_COLS) ? MAX_COLS : w;
            n       = $urandom_range(20, 60);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (n)
            begin
                if (s < wc && $urandom_range(0, 9) < 8)
                begin
                    col = $urandom_range(s, wc - 1);
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0: col = (s - 1) & 12'hFFF;
                        1: col = wc & 12'hFFF;
                        2: col = 0;
                        3: col = 4095;
                        default: col = $urandom_range(0, 4095);
                    endcase
                end
                p = pack_pair(col, rand_channel(), rand_channel(), rand_channel(),
                              rand_channel(), rand_channel(), rand_channel());
                if ($urandom_range(0, 7) == 0)
                    p.second = '0;
                gap = no_idle ? 0 : $urandom_range(0, 7);
                send_pair(p, gap);
                random_sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        pair_drv    = '0;
        cfg_start   = '0;
        cfg_width   = sfb_pkg::WIDTH_RESET;
        mismatches  = 0;
        cycles      = 0;
        random_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_overlap_edges();
        test_black_warped();
        test_empty_overlap();
        test_wide_width();
        test_random();
        drain_pipeline();

        if (mismatches == 0)
            $display("seam_linear_feather_blend_tb: done, clean");
        else
            $display("seam_linear_feather_blend_tb: done, errors");
        $finish;
    end

endmodule
